@@ src/mcw_pkg.sv @@
// Shared types, codes and sizes for the multi-client watchdog.
// No dependencies.
`timescale 1ns / 1ps
package mcw_pkg;

  localparam int CLIENTS = 16;
  localparam int IDX_W   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W   = IDX_W + 1;

  localparam int KEY_W = 16;
  localparam int PID_W = 22;
  localparam int MS_W  = 32;
  localparam int RC_W  = 8;
  localparam int CMD_W = 3;
  localparam int KND_W = 2;

  localparam logic [RC_W-1:0] REBOOT_LIM_RST = 8'd3;
  localparam logic [MS_W-1:0] DEAD_HOLD_RST  = 32'd100000;
  localparam logic [RC_W-1:0] RC_MAX         = 8'd255;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FEED   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETTMO = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REG    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNREG  = 3'd6;

  // Result kinds
  localparam logic [KND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KND_W-1:0] KIND_KILL   = 2'd1;
  localparam logic [KND_W-1:0] KIND_REBOOT = 2'd2;
  localparam logic [KND_W-1:0] KIND_DONE   = 2'd3;

  // Slot states
  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_REG  = 2'd1;
  localparam logic [1:0] SLOT_RUN  = 2'd2;
  localparam logic [1:0] SLOT_DEAD = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_REBOOT_LIM = 2'd0;
  localparam logic [1:0] CFG_DEAD_HOLD  = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PID_W-1:0] pid;
    logic [MS_W-1:0]  fed_ms;
    logic [MS_W-1:0]  timeout;
    logic [RC_W-1:0]  reg_count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [RC_W-1:0] reboot_lim;
    logic [MS_W-1:0] dead_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [KND_W-1:0] kind;
    logic             status;
    logic [CMD_W-1:0] echo;
    logic [KEY_W-1:0] key;
    logic [PID_W-1:0] pid;
    logic             last;
  } res_t;

endpackage

@@ src/mcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mcw_engine.sv @@
// Slot scan sequencer: walks the slot RAM one entry a cycle for ticks and lookups.
// Depends on mcw_pkg and mcw_ram.
`timescale 1ns / 1ps
module mcw_engine
  import mcw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMD_W-1:0] command_i,
  input  logic [KEY_W-1:0] client_key_i,
  input  logic [PID_W-1:0] process_id_i,
  input  logic [MS_W-1:0]  timeout_value_i,
  input  cfg_t             cfg_i,
  output logic             busy_o,
  output res_t             res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_REBOOT = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;
  localparam logic [2:0] S_ACT    = 3'd4;

  localparam logic [CNT_W-1:0] NUM_SLOTS = CNT_W'(CLIENTS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CLIENTS - 1);

  logic [2:0]       st_q, st_d;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [PID_W-1:0] pid_q;
  logic [MS_W-1:0]  tmo_q;
  logic [MS_W-1:0]  now_q, now_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             pv_q, pv_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [1:0]       slot_st_q [CLIENTS];
  logic [1:0]       slot_st_d [CLIENTS];
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  slot_t            hit_data_q, hit_data_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             rbt_q, rbt_d;
  logic [KEY_W-1:0] rkey_q, rkey_d;

  logic             re;
  logic             we;
  logic [IDX_W-1:0] waddr;
  slot_t            wdata;
  slot_t            rdata;
  logic [MS_W-1:0]  age;
  logic [1:0]       cur_st, new_st;
  logic             kill;
  logic             accept;

  mcw_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CLIENTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign busy_o = (st_q != S_IDLE);
  assign accept = start_i && (st_q == S_IDLE);
  assign cur_st = slot_st_q[pidx_q];
  assign age    = now_q - rdata.fed_ms;
  assign kill   = (cur_st == SLOT_RUN) && (age >= rdata.timeout);

  always_comb begin
    st_d       = st_q;
    now_d      = now_q;
    rd_idx_d   = rd_idx_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    slot_st_d  = slot_st_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_data_d = hit_data_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    rbt_d      = rbt_q;
    rkey_d     = rkey_q;
    re         = 1'b0;
    we         = 1'b0;
    waddr      = pidx_q;
    wdata      = rdata;
    new_st     = cur_st;
    res_o      = '0;

    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          st_d     = S_SCAN;
          rd_idx_d = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          rbt_d    = 1'b0;
          if (command_i == CMD_TICK) begin
            now_d = now_q + 1'b1;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is processed
        if (rd_idx_q < NUM_SLOTS) begin
          re       = 1'b1;
          pv_d     = 1'b1;
          pidx_d   = rd_idx_q[IDX_W-1:0];
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (pv_q) begin
          if (cmd_q == CMD_TICK) begin
            if (kill) begin
              we          = 1'b1;
              wdata       = rdata;
              wdata.pid   = '0;
              new_st      = SLOT_DEAD;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_KILL;
              res_o.key   = rdata.key;
              res_o.pid   = rdata.pid;
            end
            if ((new_st == SLOT_DEAD) && !rbt_q &&
                (rdata.reg_count >= cfg_i.reboot_lim)) begin
              rbt_d  = 1'b1;
              rkey_d = rdata.key;
            end
            if ((new_st == SLOT_DEAD) && (age > cfg_i.dead_hold_ms)) begin
              new_st = SLOT_FREE;
            end
            slot_st_d[pidx_q] = new_st;
          end else begin
            if ((cur_st != SLOT_FREE) && (rdata.key == key_q) && !hit_q) begin
              hit_d      = 1'b1;
              hit_idx_d  = pidx_q;
              hit_data_d = rdata;
            end
            if ((cur_st == SLOT_FREE) && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = pidx_q;
            end
          end
          if (pidx_q == LAST_IDX) begin
            if (cmd_q != CMD_TICK) begin
              st_d = S_ACT;
            end else if (rbt_d) begin
              st_d = S_REBOOT;
            end else begin
              st_d = S_DONE;
            end
          end
        end
      end
      S_REBOOT: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_REBOOT;
        res_o.key   = rkey_q;
        st_d        = S_DONE;
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_DONE;
        res_o.last  = 1'b1;
        st_d        = S_IDLE;
      end
      S_ACT: begin
        res_o.valid  = 1'b1;
        res_o.kind   = KIND_ACK;
        res_o.echo   = cmd_q;
        res_o.key    = key_q;
        res_o.last   = 1'b1;
        res_o.status = !hit_q;
        waddr        = hit_idx_q;
        wdata        = hit_data_q;
        st_d         = S_IDLE;
        case (cmd_q)
          CMD_START: begin
            if (hit_q) begin
              we                   = 1'b1;
              wdata.fed_ms         = now_q;
              slot_st_d[hit_idx_q] = SLOT_RUN;
            end
          end
          CMD_STOP: begin
            if (hit_q) begin
              slot_st_d[hit_idx_q] = SLOT_REG;
            end
          end
          CMD_FEED: begin
            we           = hit_q;
            wdata.fed_ms = now_q;
          end
          CMD_SETTMO: begin
            we            = hit_q;
            wdata.timeout = tmo_q;
          end
          CMD_REG: begin
            if (hit_q) begin
              we        = 1'b1;
              wdata.pid = pid_q;
              if (hit_data_q.reg_count != RC_MAX) begin
                wdata.reg_count = hit_data_q.reg_count + 1'b1;
              end
            end else if (free_q) begin
              // claim the lowest free slot with fresh contents
              we                    = 1'b1;
              waddr                 = free_idx_q;
              wdata.key             = key_q;
              wdata.pid             = pid_q;
              wdata.fed_ms          = '0;
              wdata.timeout         = '0;
              wdata.reg_count       = RC_W'(1);
              slot_st_d[free_idx_q] = SLOT_REG;
              res_o.status          = 1'b0;
            end
          end
          CMD_UNREG: begin
            if (hit_q) begin
              slot_st_d[hit_idx_q] = SLOT_FREE;
            end
          end
          default: begin
            res_o.status = 1'b1;
          end
        endcase
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      now_q    <= '0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      rbt_q    <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        slot_st_q[i] <= SLOT_FREE;
      end
    end else begin
      st_q      <= st_d;
      now_q     <= now_d;
      rd_idx_q  <= rd_idx_d;
      pv_q      <= pv_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      rbt_q     <= rbt_d;
      slot_st_q <= slot_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= client_key_i;
      pid_q <= process_id_i;
      tmo_q <= timeout_value_i;
    end
    pidx_q     <= pidx_d;
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    free_idx_q <= free_idx_d;
    rkey_q     <= rkey_d;
  end

endmodule

@@ src/multi_client_watchdog.sv @@
// Top level of the multi-client watchdog: config registers, result register, engine.
// Depends on mcw_pkg, mcw_engine and mcw_ram.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive command_i, client_key_i, process_id_i and
//   timeout_value_i with start high; the word is taken at the edge where
//   busy is low. Busy stays high until the engine has produced every result.
//   Result channel: each result word is shown for one cycle with
//   result_valid_o high; last_o marks the final word of a command. The
//   receiver cannot stall, so words are never held back.
//   Config channel: cfg_ready_o is always high; index 0 writes the restart
//   limit, index 1 the dead hold time, other indexes are ignored. Write only
//   while busy is low and no result is still due.
// Timing
//   Every command scans the slot RAM one entry a cycle over its single read
//   port. A lookup command then does the write-back and the ack. A tick
//   streams kill reports during the scan, then an optional reboot word and
//   the done word. Each result reaches the ports in the cycle after the
//   engine forms it.
// Reset
//   All slots free, clock at zero, limit 3, hold time 100000 ms. The slot
//   states live in flip-flops, so no RAM clearing pass is needed.
module multi_client_watchdog
  import mcw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] command_i,
  input  logic [KEY_W-1:0] client_key_i,
  input  logic [PID_W-1:0] process_id_i,
  input  logic [MS_W-1:0]  timeout_value_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [MS_W-1:0]  cfg_data_i,
  output logic             result_valid_o,
  output logic [KND_W-1:0] kind_o,
  output logic             status_o,
  output logic [CMD_W-1:0] command_echo_o,
  output logic [KEY_W-1:0] reported_key_o,
  output logic [PID_W-1:0] reported_pid_o,
  output logic             last_o
);

  cfg_t cfg_q, cfg_d;
  res_t res;
  res_t res_q;

  assign cfg_ready_o = 1'b1;

  // decode the config write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REBOOT_LIM: cfg_d.reboot_lim   = cfg_data_i[RC_W-1:0];
        CFG_DEAD_HOLD:  cfg_d.dead_hold_ms = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  mcw_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .command_i      (command_i),
    .client_key_i   (client_key_i),
    .process_id_i   (process_id_i),
    .timeout_value_i(timeout_value_i),
    .cfg_i          (cfg_q),
    .busy_o         (busy),
    .res_o          (res)
  );

  // hold config; register each result word for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reboot_lim   <= REBOOT_LIM_RST;
      cfg_q.dead_hold_ms <= DEAD_HOLD_RST;
      res_q              <= '0;
    end else begin
      cfg_q <= cfg_d;
      res_q <= res;
    end
  end

  assign result_valid_o = res_q.valid;
  assign kind_o         = res_q.kind;
  assign status_o       = res_q.status;
  assign command_echo_o = res_q.echo;
  assign reported_key_o = res_q.key;
  assign reported_pid_o = res_q.pid;
  assign last_o         = res_q.last;

endmodule

@@ src/mcw_checker.sv @@
// Port-level checker for the multi-client watchdog and its bind.
// Depends on mcw_pkg and multi_client_watchdog.
`timescale 1ns / 1ps
module mcw_checker
  import mcw_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic [KND_W-1:0] kind_o,
  input logic             status_o,
  input logic             last_o
);

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_ACK) |-> last_o)
    else $error("ack word without last");

  a_kill_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_KILL) |-> !last_o && !status_o)
    else $error("kill word marked last or failed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KIND_DONE) |-> last_o && !status_o)
    else $error("tick done malformed");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken without busy");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("word follows last word immediately");

endmodule

bind multi_client_watchdog mcw_checker u_mcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .kind_o        (kind_o),
  .status_o      (status_o),
  .last_o        (last_o)
);
